>>> sv/sliding_window_correlation_defines.svh
// Assertion macros for the sliding window correlation block.
// Each macro expects signals named clock and reset in the scope of use.
`ifndef SLIDING_WINDOW_CORRELATION_DEFINES_SVH
`define SLIDING_WINDOW_CORRELATION_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define SWC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define SWC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/swc_pkg.sv
`timescale 1ns / 1ps
package swc_pkg;

   localparam int WLEN_BITS     = 11;
   localparam int OVL_BITS      = 10;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [WLEN_BITS-1:0] WLEN_RESET = 11'd64;
   localparam logic [OVL_BITS-1:0]  OVL_RESET  = 10'd0;

   typedef enum logic [0:0] {
      REG_WINDOW_LEN  = 1'b0,
      REG_OVERLAP_LEN = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [WLEN_BITS-1:0] window_len;
      logic [OVL_BITS-1:0]  overlap_len;
      logic                 restart;
   } cfg_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_OLD,
      FR_SUM
   } front_state_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_NSXX,
      BK_SXSX,
      BK_NSYY,
      BK_SYSY,
      BK_CHECK,
      BK_NSXY,
      BK_SXSY,
      BK_DEN,
      BK_NUM,
      BK_DIV,
      BK_SQRT,
      BK_OUT
   } back_state_type;

endpackage

>>> sv/swc_if.sv
`timescale 1ns / 1ps
interface swc_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] x_sample;
   logic signed [SAMPLE_BITS-1:0] y_sample;

   modport source (output valid, output x_sample, output y_sample, input ready);
   modport sink (input valid, input x_sample, input y_sample, output ready);
endinterface

interface swc_rsp_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] coefficient;
   logic                          degenerate;

   modport source (output valid, output coefficient, output degenerate, input ready);
   modport sink (input valid, input coefficient, input degenerate, output ready);
endinterface

>>> sv/sliding_window_correlation.sv
`timescale 1ns / 1ps
// Sliding-window Pearson correlation of two signed sample streams. Each word on req_chan carries
// one (x, y) pair; the front end writes the history ring and fetches the leaving pair, then
// updates the five running sums, and can take the next pair while it updates them. When the
// first window fills, and every window_len - overlap_len pairs after that (1 when the overlap
// is not below the window), a snapshot of the sums is queued and the back end works out r in
// signed Q1.15, rounded half away from zero and clipped at +1. The back end shares one
// bit-serial multiplier over eight products of 2*(SAMPLE_BITS+log2(WINDOW_MAX))-bit operands,
// then a one-bit-a-cycle divider and square root, so with short hops the queue fills and the
// front end stalls. A window with zero variance gives coefficient 0 with degenerate set.
// Writing either register over APB (window_len at 0x0, overlap_len at 0x4) restarts the stream;
// write them only when idle.
module sliding_window_correlation #(
   parameter int WINDOW_MAX = 1024,
   parameter int SAMPLE_BITS = 16,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                               clock,
   input  logic                               reset,
   swc_req_if.sink                            req_chan,
   swc_rsp_if.source                          rsp_chan,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [swc_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [swc_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [swc_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready
);

   localparam int AW     = $clog2(WINDOW_MAX);
   localparam int NW     = AW + 1;
   localparam int XW     = SAMPLE_BITS + AW + 1;
   localparam int PW     = 2 * SAMPLE_BITS + AW;
   localparam int SNAP_W = NW + 2 * XW + 3 * PW;

   logic [swc_pkg::WLEN_BITS-1:0] window_len_ff;
   logic [swc_pkg::OVL_BITS-1:0]  overlap_len_ff;
   swc_pkg::reg_index_type        reg_index;
   swc_pkg::cfg_type              cfg;
   logic                          csr_write;

   logic              push_valid, push_ready, pop_valid, pop_ready;
   logic [SNAP_W-1:0] push_data, pop_data;

   assign pready    = 1'b1;
   assign reg_index = swc_pkg::reg_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff  <= swc_pkg::WLEN_RESET;
         overlap_len_ff <= swc_pkg::OVL_RESET;
      end else if (csr_write) begin
         case (reg_index)
            swc_pkg::REG_WINDOW_LEN:  window_len_ff  <= pwdata[swc_pkg::WLEN_BITS-1:0];
            swc_pkg::REG_OVERLAP_LEN: overlap_len_ff <= pwdata[swc_pkg::OVL_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         swc_pkg::REG_WINDOW_LEN:  prdata = swc_pkg::CSR_DATA_BITS'(window_len_ff);
         swc_pkg::REG_OVERLAP_LEN: prdata = swc_pkg::CSR_DATA_BITS'(overlap_len_ff);
         default:                  prdata = '0;
      endcase
   end

   assign cfg.window_len  = window_len_ff;
   assign cfg.overlap_len = overlap_len_ff;
   assign cfg.restart     = csr_write;

   swc_front #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req        (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   swc_queue #(
      .WIDTH (SNAP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   swc_back #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp       (rsp_chan)
   );

endmodule

>>> sv/swc_ram.sv
`timescale 1ns / 1ps
module swc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old word when both ports hit the same address
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/swc_queue.sv
`timescale 1ns / 1ps
module swc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (32'(wr_ff) == DEPTH - 1) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (32'(rd_ff) == DEPTH - 1) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> sv/swc_front.sv
`timescale 1ns / 1ps
module swc_front #(
   parameter int WINDOW_MAX = 1024,
   parameter int SAMPLE_BITS = 16,
   localparam int AW = $clog2(WINDOW_MAX),
   localparam int NW = AW + 1,
   localparam int XW = SAMPLE_BITS + AW + 1,
   localparam int PW = 2 * SAMPLE_BITS + AW,
   localparam int SNAP_W = NW + 2 * XW + 3 * PW
) (
   input  logic              clock,
   input  logic              reset,
   input  swc_pkg::cfg_type  cfg,
   swc_req_if.sink           req,
   output logic              push_valid,
   input  logic              push_ready,
   output logic [SNAP_W-1:0] push_data
);

   localparam int SB = SAMPLE_BITS;

   swc_pkg::front_state_type state_ff, state_in;

   logic [AW-1:0] write_pos_ff, write_pos_in, pos;
   logic [NW-1:0] fill_ff, fill_in, hop_ff, hop_in, n, hop;
   logic          emit_ff, emit_in, sub_ff, sub_in;
   logic          accept, proceed;

   logic signed [SB-1:0]   x_ff, y_ff, ox_ff, oy_ff, ox_w, oy_w;
   logic signed [2*SB-1:0] nxy_ff, nxx_ff, nyy_ff, oxy_ff, oxx_ff, oyy_ff;
   logic signed [XW-1:0]   sx_ff, sy_ff, sx_in, sy_in;
   logic signed [PW-1:0]   sxy_ff, sxx_ff, syy_ff, sxy_in, sxx_in, syy_in;
   logic [2*SB-1:0]        ram_rd;

   // effective window, hop and ring slot
   always_comb begin
      if (cfg.window_len < 11'd2) begin
         n = NW'(2);
      end else if (32'(cfg.window_len) > WINDOW_MAX) begin
         n = NW'(WINDOW_MAX);
      end else begin
         n = NW'(cfg.window_len);
      end
      if (32'(cfg.overlap_len) < 32'(n)) begin
         hop = n - NW'(cfg.overlap_len);
      end else begin
         hop = NW'(1);
      end
      pos = (32'(write_pos_ff) < 32'(n)) ? write_pos_ff : '0;
   end

   assign proceed   = !emit_ff || push_ready;
   assign req.ready = (state_ff == swc_pkg::FR_IDLE) ||
                      ((state_ff == swc_pkg::FR_SUM) && proceed);
   assign accept    = req.valid && req.ready;

   always_comb begin
      state_in     = state_ff;
      write_pos_in = write_pos_ff;
      fill_in      = fill_ff;
      hop_in       = hop_ff;
      emit_in      = emit_ff;
      sub_in       = sub_ff;
      case (state_ff)
         swc_pkg::FR_IDLE: begin
            if (accept) begin
               state_in = swc_pkg::FR_OLD;
            end
         end
         swc_pkg::FR_OLD: begin
            state_in = swc_pkg::FR_SUM;
         end
         swc_pkg::FR_SUM: begin
            if (accept) begin
               state_in = swc_pkg::FR_OLD;
            end else if (proceed) begin
               state_in = swc_pkg::FR_IDLE;
            end
         end
         default: begin
            state_in = swc_pkg::FR_IDLE;
         end
      endcase
      if (accept) begin
         sub_in       = (fill_ff >= n);
         write_pos_in = (32'(pos) + 1 >= 32'(n)) ? '0 : pos + 1'b1;
         emit_in      = 1'b0;
         if (fill_ff < n) begin
            fill_in = fill_ff + 1'b1;
            if (fill_ff + 1'b1 == n) begin
               emit_in = 1'b1;
               hop_in  = '0;
            end
         end else begin
            hop_in = hop_ff + 1'b1;
            if (hop_ff + 1'b1 >= hop) begin
               emit_in = 1'b1;
               hop_in  = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg.restart) begin
         state_ff     <= swc_pkg::FR_IDLE;
         write_pos_ff <= '0;
         fill_ff      <= '0;
         hop_ff       <= '0;
         emit_ff      <= 1'b0;
         sub_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         write_pos_ff <= write_pos_in;
         fill_ff      <= fill_in;
         hop_ff       <= hop_in;
         emit_ff      <= emit_in;
         sub_ff       <= sub_in;
      end
   end

   swc_ram #(
      .WIDTH (2 * SB),
      .DEPTH (WINDOW_MAX)
   ) u_history (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (pos),
      .wr_data ({req.x_sample, req.y_sample}),
      .rd_en   (accept),
      .rd_addr (pos),
      .rd_data (ram_rd)
   );

   // drop the leaving sample only once the window is full
   assign ox_w = sub_ff ? signed'(ram_rd[2*SB-1:SB]) : '0;
   assign oy_w = sub_ff ? signed'(ram_rd[SB-1:0]) : '0;

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff <= req.x_sample;
         y_ff <= req.y_sample;
      end
      if (state_ff == swc_pkg::FR_OLD) begin
         ox_ff  <= ox_w;
         oy_ff  <= oy_w;
         oxy_ff <= ox_w * oy_w;
         oxx_ff <= ox_w * ox_w;
         oyy_ff <= oy_w * oy_w;
         nxy_ff <= x_ff * y_ff;
         nxx_ff <= x_ff * x_ff;
         nyy_ff <= y_ff * y_ff;
      end
   end

   always_comb begin
      sx_in  = sx_ff + XW'(x_ff) - XW'(ox_ff);
      sy_in  = sy_ff + XW'(y_ff) - XW'(oy_ff);
      sxy_in = sxy_ff + PW'(nxy_ff) - PW'(oxy_ff);
      sxx_in = sxx_ff + PW'(nxx_ff) - PW'(oxx_ff);
      syy_in = syy_ff + PW'(nyy_ff) - PW'(oyy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset || cfg.restart) begin
         sx_ff  <= '0;
         sy_ff  <= '0;
         sxy_ff <= '0;
         sxx_ff <= '0;
         syy_ff <= '0;
      end else if ((state_ff == swc_pkg::FR_SUM) && proceed) begin
         sx_ff  <= sx_in;
         sy_ff  <= sy_in;
         sxy_ff <= sxy_in;
         sxx_ff <= sxx_in;
         syy_ff <= syy_in;
      end
   end

   assign push_valid = (state_ff == swc_pkg::FR_SUM) && emit_ff;
   assign push_data  = {n, sx_in, sy_in, sxy_in, sxx_in, syy_in};

endmodule

>>> sv/swc_back.sv
`timescale 1ns / 1ps
module swc_back #(
   parameter int WINDOW_MAX = 1024,
   parameter int SAMPLE_BITS = 16,
   localparam int AW = $clog2(WINDOW_MAX),
   localparam int NW = AW + 1,
   localparam int XW = SAMPLE_BITS + AW + 1,
   localparam int PW = 2 * SAMPLE_BITS + AW,
   localparam int SNAP_W = NW + 2 * XW + 3 * PW
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  logic [SNAP_W-1:0] pop_data,
   swc_rsp_if.source         rsp
);

   localparam int SB   = SAMPLE_BITS;
   localparam int MW   = 2 * SB + 2 * AW;
   localparam int RW   = 2 * MW + 1;
   localparam int QW   = 2 * SB + 1;
   localparam int RADW = QW + 1;
   localparam int SRW  = SB + 4;
   localparam int CW   = $clog2(MW + 1);
   localparam logic [SB:0] QMAX = (SB + 1)'((1 << (SB - 1)) - 1);

   swc_pkg::back_state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done, is_mul;

   logic [MW-1:0]   n_ff, sx_ff, sy_ff, sxy_ff, sxx_ff, syy_ff;
   logic            sxs_ff, sys_ff, sxys_ff, neg_ff;
   logic [MW-1:0]   op_a, op_b, b_ff, vx_ff, vy_ff, cov_ff;
   logic [2*MW-1:0] a_ff, acc_ff, tmp_ff, den_ff, prod_w;
   logic [RW-1:0]   rem_ff, rem2;
   logic            div_ge;
   logic [QW-1:0]   quo_ff, quo_next;
   logic [RADW-1:0] rad_ff;
   logic [SB:0]     root_ff, root_next, qv;
   logic [SRW-1:0]  srem_ff, srem2, trial;
   logic            sq_ge;
   logic signed [SB-1:0] coef_ff, coef_w;
   logic            degen_ff;

   function automatic logic [MW-1:0] mag_of(input logic signed [MW-1:0] v);
      return v[MW-1] ? MW'(-v) : MW'(v);
   endfunction

   // snapshot fields, most significant first: n, sx, sy, sxy, sxx, syy
   logic signed [XW-1:0] snap_sx, snap_sy;
   logic signed [PW-1:0] snap_sxy, snap_sxx, snap_syy;
   logic [NW-1:0]        snap_n;
   assign snap_syy = signed'(pop_data[PW-1:0]);
   assign snap_sxx = signed'(pop_data[2*PW-1:PW]);
   assign snap_sxy = signed'(pop_data[3*PW-1:2*PW]);
   assign snap_sy  = signed'(pop_data[3*PW+XW-1:3*PW]);
   assign snap_sx  = signed'(pop_data[3*PW+2*XW-1:3*PW+XW]);
   assign snap_n   = pop_data[SNAP_W-1:3*PW+2*XW];

   assign done   = (cnt_ff == CW'(MW));
   assign prod_w = acc_ff + (b_ff[0] ? a_ff : '0);

   always_comb begin
      is_mul = 1'b1;
      op_a   = n_ff;
      op_b   = sxx_ff;
      case (state_ff)
         swc_pkg::BK_NSXX: begin
            op_a = n_ff;
            op_b = sxx_ff;
         end
         swc_pkg::BK_SXSX: begin
            op_a = sx_ff;
            op_b = sx_ff;
         end
         swc_pkg::BK_NSYY: begin
            op_a = n_ff;
            op_b = syy_ff;
         end
         swc_pkg::BK_SYSY: begin
            op_a = sy_ff;
            op_b = sy_ff;
         end
         swc_pkg::BK_NSXY: begin
            op_a = n_ff;
            op_b = sxy_ff;
         end
         swc_pkg::BK_SXSY: begin
            op_a = sx_ff;
            op_b = sy_ff;
         end
         swc_pkg::BK_DEN: begin
            op_a = vx_ff;
            op_b = vy_ff;
         end
         swc_pkg::BK_NUM: begin
            op_a = cov_ff;
            op_b = cov_ff;
         end
         default: begin
            is_mul = 1'b0;
         end
      endcase
   end

   // restoring division, one quotient bit a cycle
   always_comb begin
      rem2     = {rem_ff[RW-2:0], 1'b0};
      div_ge   = (rem2 >= RW'(den_ff));
      quo_next = {quo_ff[QW-2:0], div_ge};
   end

   // digit-by-digit square root, one root bit a cycle
   always_comb begin
      srem2     = {srem_ff[SRW-3:0], rad_ff[RADW-1 -: 2]};
      trial     = SRW'({root_ff, 2'b01});
      sq_ge     = (srem2 >= trial);
      root_next = {root_ff[SB-1:0], sq_ge};
      qv        = (SB + 1)'(((SB + 2)'(root_next) + 1'b1) >> 1);
      if (neg_ff) begin
         coef_w = signed'(SB'((SB + 1)'(0) - qv));
      end else if (qv > QMAX) begin
         coef_w = signed'(SB'(QMAX));
      end else begin
         coef_w = signed'(SB'(qv));
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      if (is_mul) begin
         if (done) begin
            cnt_in = '0;
            case (state_ff)
               swc_pkg::BK_NSXX: state_in = swc_pkg::BK_SXSX;
               swc_pkg::BK_SXSX: state_in = swc_pkg::BK_NSYY;
               swc_pkg::BK_NSYY: state_in = swc_pkg::BK_SYSY;
               swc_pkg::BK_SYSY: state_in = swc_pkg::BK_CHECK;
               swc_pkg::BK_NSXY: state_in = swc_pkg::BK_SXSY;
               swc_pkg::BK_SXSY: state_in = swc_pkg::BK_DEN;
               swc_pkg::BK_DEN:  state_in = swc_pkg::BK_NUM;
               swc_pkg::BK_NUM:  state_in = swc_pkg::BK_DIV;
               default:          state_in = swc_pkg::BK_IDLE;
            endcase
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end else begin
         case (state_ff)
            swc_pkg::BK_IDLE: begin
               if (pop_valid) begin
                  state_in = swc_pkg::BK_NSXX;
               end
            end
            swc_pkg::BK_CHECK: begin
               state_in = ((vx_ff == '0) || (vy_ff == '0)) ? swc_pkg::BK_OUT
                                                           : swc_pkg::BK_NSXY;
            end
            swc_pkg::BK_DIV: begin
               if (cnt_ff == CW'(2 * SB - 1)) begin
                  cnt_in   = '0;
                  state_in = swc_pkg::BK_SQRT;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            swc_pkg::BK_SQRT: begin
               if (cnt_ff == CW'(SB)) begin
                  cnt_in   = '0;
                  state_in = swc_pkg::BK_OUT;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            swc_pkg::BK_OUT: begin
               if (rsp.ready) begin
                  state_in = swc_pkg::BK_IDLE;
               end
            end
            default: begin
               state_in = swc_pkg::BK_IDLE;
               cnt_in   = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swc_pkg::BK_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (is_mul) begin
         if (cnt_ff == '0) begin
            a_ff   <= (2 * MW)'(op_a);
            b_ff   <= op_b;
            acc_ff <= '0;
         end else begin
            acc_ff <= prod_w;
            a_ff   <= a_ff << 1;
            b_ff   <= b_ff >> 1;
         end
      end
      case (state_ff)
         swc_pkg::BK_IDLE: begin
            if (pop_valid) begin
               n_ff    <= MW'(snap_n);
               sx_ff   <= mag_of(MW'(snap_sx));
               sy_ff   <= mag_of(MW'(snap_sy));
               sxy_ff  <= mag_of(MW'(snap_sxy));
               sxx_ff  <= mag_of(MW'(snap_sxx));
               syy_ff  <= mag_of(MW'(snap_syy));
               sxs_ff  <= snap_sx[XW-1];
               sys_ff  <= snap_sy[XW-1];
               sxys_ff <= snap_sxy[PW-1];
            end
         end
         swc_pkg::BK_NSXX, swc_pkg::BK_NSYY, swc_pkg::BK_NSXY: begin
            if (done) begin
               tmp_ff <= prod_w;
            end
         end
         swc_pkg::BK_SXSX: begin
            if (done) begin
               vx_ff <= (tmp_ff >= prod_w) ? MW'(tmp_ff - prod_w) : '0;
            end
         end
         swc_pkg::BK_SYSY: begin
            if (done) begin
               vy_ff <= (tmp_ff >= prod_w) ? MW'(tmp_ff - prod_w) : '0;
            end
         end
         swc_pkg::BK_CHECK: begin
            coef_ff  <= '0;
            degen_ff <= 1'b1;
         end
         swc_pkg::BK_SXSY: begin
            // covariance as sign and magnitude of n*Sxy - Sx*Sy
            if (done) begin
               if (sxys_ff != (sxs_ff ^ sys_ff)) begin
                  cov_ff <= MW'(tmp_ff + prod_w);
                  neg_ff <= sxys_ff;
               end else if (tmp_ff >= prod_w) begin
                  cov_ff <= MW'(tmp_ff - prod_w);
                  neg_ff <= sxys_ff;
               end else begin
                  cov_ff <= MW'(prod_w - tmp_ff);
                  neg_ff <= !sxys_ff;
               end
            end
         end
         swc_pkg::BK_DEN: begin
            if (done) begin
               den_ff <= prod_w;
            end
         end
         swc_pkg::BK_NUM: begin
            if (done) begin
               if (prod_w >= den_ff) begin
                  rem_ff <= RW'(prod_w - den_ff);
                  quo_ff <= QW'(1);
               end else begin
                  rem_ff <= RW'(prod_w);
                  quo_ff <= '0;
               end
            end
         end
         swc_pkg::BK_DIV: begin
            rem_ff <= div_ge ? rem2 - RW'(den_ff) : rem2;
            quo_ff <= quo_next;
            if (cnt_ff == CW'(2 * SB - 1)) begin
               rad_ff  <= {1'b0, quo_next};
               root_ff <= '0;
               srem_ff <= '0;
            end
         end
         swc_pkg::BK_SQRT: begin
            srem_ff <= sq_ge ? srem2 - trial : srem2;
            root_ff <= root_next;
            rad_ff  <= rad_ff << 2;
            if (cnt_ff == CW'(SB)) begin
               coef_ff  <= coef_w;
               degen_ff <= 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   assign pop_ready       = (state_ff == swc_pkg::BK_IDLE);
   assign rsp.valid       = (state_ff == swc_pkg::BK_OUT);
   assign rsp.coefficient = coef_ff;
   assign rsp.degenerate  = degen_ff;

endmodule

>>> sv/swc_checker.sv
`timescale 1ns / 1ps
`include "sliding_window_correlation_defines.svh"
module swc_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SAMPLE_BITS-1:0] coefficient,
   input logic                          degenerate
);

   // a held word keeps its value until taken
   `SWC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(coefficient) && $stable(degenerate), "result word changed while stalled")

   `SWC_ASSERT_SAME(a_degen_zero, rsp_valid && degenerate, coefficient == '0, "degenerate window with nonzero coefficient")

   // the front end drops ready after it takes a pair
   `SWC_ASSERT_NEXT(a_req_gap, req_valid && req_ready, !req_ready, "input taken on consecutive cycles")

endmodule

bind sliding_window_correlation swc_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_swc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .coefficient (rsp_chan.coefficient),
   .degenerate  (rsp_chan.degenerate)
);

>>> tb/sliding_window_correlation_test.sv
`timescale 1ns / 1ps
module sliding_window_correlation_test;

   localparam int HISTORY_DEPTH = 1024;
   localparam int SETTLE_CYCLES = 700;
   localparam int STALL_LIMIT   = 20000;

   typedef struct {
      logic signed [15:0] coefficient;
      bit                 degenerate;
   } pearson_word_type;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      bit                 pinned;
      pearson_word_type   word;
   } sample_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [swc_pkg::CSR_ADDR_BITS-1:0] paddr = '0;
   logic [swc_pkg::CSR_DATA_BITS-1:0] pwdata = '0;
   logic [swc_pkg::CSR_DATA_BITS-1:0] prdata;
   logic pready;

   swc_req_if #(.SAMPLE_BITS(16)) req ();
   swc_rsp_if #(.SAMPLE_BITS(16)) rsp ();

   sliding_window_correlation dut (
      .clock(clock), .reset(reset), .req_chan(req), .rsp_chan(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // predictor copy of the block state
   logic [swc_pkg::WLEN_BITS-1:0] window_cfg = swc_pkg::WLEN_RESET;
   logic [swc_pkg::OVL_BITS-1:0]  overlap_cfg = swc_pkg::OVL_RESET;
   shortint x_ring [HISTORY_DEPTH];
   shortint y_ring [HISTORY_DEPTH];
   longint acc_x, acc_y, acc_xy, acc_xx, acc_yy;
   int ring_pos, ring_fill, hop_count;

   pearson_word_type pending_q[$];
   sample_row_type   row_q[$];
   int  failures = 0;
   int  quiet_cycles = 0;
   bit  sender_calm = 1'b0, receiver_calm = 1'b0;

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      req.valid = 1'b0;
      req.x_sample = '0;
      req.y_sample = '0;
      rsp.ready = 1'b0;
   end

   function automatic void restart_stream();
      acc_x = 0; acc_y = 0; acc_xy = 0; acc_xx = 0; acc_yy = 0;
      ring_pos = 0; ring_fill = 0; hop_count = 0;
   endfunction

   function automatic logic [255:0] magnitude(longint v);
      logic [255:0] m;
      m = (v < 0) ? -v : v;
      return m;
   endfunction

   function automatic pearson_word_type pearson(int n);
      pearson_word_type w;
      longint vx, vy, cov;
      logic [255:0] den, num, lhs, odd;
      int lo, hi, mid;
      vx = n * acc_xx - acc_x * acc_x;
      vy = n * acc_yy - acc_y * acc_y;
      if (vx <= 0 || vy <= 0) begin
         w.coefficient = '0;
         w.degenerate = 1'b1;
         return w;
      end
      cov = n * acc_xy - acc_x * acc_y;
      den = magnitude(vx) * magnitude(vy);
      num = (magnitude(cov) * magnitude(cov)) << 32;
      lo = 0;
      hi = 32768;
      // largest q with (2q-1)^2 * vx*vy within 2^32 * cov^2
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         odd = 2 * mid - 1;
         lhs = odd * odd * den;
         if (lhs <= num) lo = mid;
         else hi = mid - 1;
      end
      if (cov >= 0) w.coefficient = (lo > 32767) ? 16'sd32767 : 16'(lo);
      else w.coefficient = 16'(65536 - lo);
      w.degenerate = 1'b0;
      return w;
   endfunction

   function automatic bit advance_window(longint x, longint y, output pearson_word_type w);
      int n, hop, pos;
      longint ox, oy;
      bit fire;
      n = (window_cfg < 2) ? 2 : (window_cfg > HISTORY_DEPTH ? HISTORY_DEPTH : window_cfg);
      hop = (overlap_cfg < n) ? n - overlap_cfg : 1;
      pos = (ring_pos < n) ? ring_pos : 0;
      fire = 1'b0;
      if (ring_fill >= n) begin
         ox = x_ring[pos];
         oy = y_ring[pos];
         acc_x -= ox; acc_y -= oy;
         acc_xy -= ox * oy; acc_xx -= ox * ox; acc_yy -= oy * oy;
      end
      x_ring[pos] = shortint'(x);
      y_ring[pos] = shortint'(y);
      acc_x += x; acc_y += y;
      acc_xy += x * y; acc_xx += x * x; acc_yy += y * y;
      ring_pos = (pos + 1 >= n) ? 0 : pos + 1;
      if (ring_fill < n) begin
         ring_fill++;
         if (ring_fill == n) begin
            fire = 1'b1;
            hop_count = 0;
         end
      end else begin
         hop_count++;
         if (hop_count >= hop) begin
            fire = 1'b1;
            hop_count = 0;
         end
      end
      if (fire) w = pearson(n);
      return fire;
   endfunction

   // stall pattern on the result side
   always @(posedge clock) begin
      rsp.ready <= receiver_calm ? 1'b1 : ($urandom_range(99) >= 32);
   end

   always @(posedge clock) begin
      pearson_word_type w, want;
      sample_row_type row;
      bit fired;
      if (!reset) begin
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (req.valid && req.ready) begin
            fired = advance_window(longint'(req.x_sample), longint'(req.y_sample), w);
            if (row_q.size() > 0) begin
               row = row_q.pop_front();
               if (row.pinned) pending_q.push_back(row.word);
               else if (fired) pending_q.push_back(w);
            end else if (fired) begin
               pending_q.push_back(w);
            end
         end
         if (rsp.valid && rsp.ready) begin
            if (pending_q.size() == 0) begin
               failures++;
               $display("%0t: unexpected word coefficient=%0d degenerate=%0b", $time,
                        rsp.coefficient, rsp.degenerate);
            end else begin
               want = pending_q.pop_front();
               if (rsp.coefficient !== want.coefficient) begin
                  failures++;
                  $display("%0t: coefficient expected %0d actual %0d", $time,
                           want.coefficient, rsp.coefficient);
               end
               if (rsp.degenerate !== want.degenerate) begin
                  failures++;
                  $display("%0t: degenerate expected %0b actual %0b", $time,
                           want.degenerate, rsp.degenerate);
               end
            end
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic write_reg(swc_pkg::reg_index_type index,
                            logic [swc_pkg::CSR_DATA_BITS-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      if (index == swc_pkg::REG_WINDOW_LEN) window_cfg = value[swc_pkg::WLEN_BITS-1:0];
      else overlap_cfg = value[swc_pkg::OVL_BITS-1:0];
      restart_stream();
   endtask

   task automatic send_word(logic signed [15:0] x, logic signed [15:0] y);
      while (!sender_calm && $urandom_range(99) < 32) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.x_sample <= x;
      req.y_sample <= y;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // hold until the block has drained, then let the front end settle
   task automatic drain();
      req.valid <= 1'b0;
      while (pending_q.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_pair(int mode, output logic signed [15:0] x,
                              output logic signed [15:0] y);
      x = 16'($urandom);
      case (mode)
         0: y = 16'($urandom);
         1: y = x + 16'($urandom_range(64)) - 16'sd32;
         2: y = -x;
         3: begin
            x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            y = 16'($urandom_range(3));
         end
         default: y = x;
      endcase
   endtask

   task automatic random_phase(int wlen, int olen, int count);
      logic signed [15:0] x, y;
      int mode;
      write_reg(swc_pkg::REG_WINDOW_LEN, wlen);
      write_reg(swc_pkg::REG_OVERLAP_LEN, olen);
      mode = $urandom_range(4);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(15) == 0) mode = $urandom_range(4);
         random_pair(mode, x, y);
         send_word(x, y);
      end
      drain();
   endtask

   sample_row_type directed_rows[] = '{
      '{16'sd0, 16'sd0, 1'b0, '{16'sd0, 1'b0}},
      '{16'sd0, 16'sd0, 1'b1, '{16'sd0, 1'b1}},
      '{16'sh7fff, 16'sh7fff, 1'b1, '{16'sh7fff, 1'b0}},
      '{16'sh8000, 16'sh8000, 1'b1, '{16'sh7fff, 1'b0}},
      '{16'sh8000, 16'sh7fff, 1'b1, '{16'sd0, 1'b1}},
      '{16'sh7fff, 16'sh8000, 1'b1, '{16'sh8000, 1'b0}},
      '{16'sd1, 16'sd1, 1'b1, '{16'sh8000, 1'b0}},
      '{16'sh5555, 16'shaaaa, 1'b0, '{16'sd0, 1'b0}},
      '{16'shaaaa, 16'sh5555, 1'b0, '{16'sd0, 1'b0}},
      '{16'sh1234, 16'sh1234, 1'b0, '{16'sd0, 1'b0}},
      '{16'sh1234, 16'sh4321, 1'b0, '{16'sd0, 1'b0}},
      '{16'sh8000, 16'sh7ffe, 1'b0, '{16'sd0, 1'b0}}
   };

   initial begin
      logic signed [15:0] x, y;
      restart_stream();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: one full window at the default length
      for (int i = 0; i < 80; i++) begin
         random_pair(0, x, y);
         send_word(x, y);
      end
      drain();

      // two-sample windows advancing by one
      write_reg(swc_pkg::REG_WINDOW_LEN, 2);
      write_reg(swc_pkg::REG_OVERLAP_LEN, 1);
      foreach (directed_rows[i]) begin
         row_q.push_back(directed_rows[i]);
         send_word(directed_rows[i].x, directed_rows[i].y);
      end
      drain();

      random_phase(3, 0, 60);
      random_phase(0, 0, 40);
      random_phase(5, 4, 60);
      random_phase(8, 100, 50);
      sender_calm = 1'b1;
      receiver_calm = 1'b1;
      random_phase(16, 12, 90);
      sender_calm = 1'b0;
      receiver_calm = 1'b0;
      random_phase(1, 1023, 30);
      random_phase(32, 5, 120);
      random_phase(2047, 1023, 20);
      random_phase(64, 0, 140);

      if (failures == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
